@@ sv/lccp_pkg.sv @@
// Shared types, constants and helpers for the coefficient compress-and-pack block.
`timescale 1ns / 1ps
package lccp_pkg;

	localparam int COEFF_W = 16;        // input coefficient width
	localparam int BYTE_W  = 8;         // packed output byte
	localparam int CFG_W   = 4;         // width register
	localparam int MAX_D   = 11;        // widest compressed value
	localparam int T_W     = MAX_D;     // compressed value register width
	localparam int PEND_W  = 7;         // leftover bits, always fewer than a byte
	localparam int CNT_W   = 3;         // leftover bit count
	localparam int TOT_W   = 5;         // leftover count plus width, up to 18
	localparam int ACC_W   = T_W + PEND_W;

	localparam logic [CFG_W-1:0] D_MIN   = 4'd8;
	localparam logic [CFG_W-1:0] D_MAX   = 4'd11;
	localparam logic [CFG_W-1:0] D_RESET = 4'd11;

	typedef logic [CFG_W-1:0] width_t;
	typedef logic [T_W-1:0]   tval_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// out-of-range register codes clamp to the nearest supported width
	function automatic width_t eff_width(input width_t raw);
		width_t d;
		d = raw;
		if (raw < D_MIN) begin
			d = D_MIN;
		end else if (raw > D_MAX) begin
			d = D_MAX;
		end
		return d;
	endfunction

endpackage

@@ sv/lattice_coeff_compress_pack_top.sv @@
// Top level: lattice coefficient compression and little-endian bit packing.
`timescale 1ns / 1ps
// Takes one 16-bit coefficient per s_ transfer, reduces it fully modulo
// MODULUS, rounds x*2^d/MODULUS to d bits (d from cfg_data, 8..11; codes
// below 8 act as 8, above 11 as 11, reset value 11) and appends those bits,
// LSB first, above the bits left over from earlier coefficients. Every
// complete byte leaves on the m_ side, lowest bits first; tlast marks the
// last byte a coefficient caused (each coefficient gives one or two bytes).
// Leftover bits (up to 7) are never flushed; a stream whose bit total is a
// multiple of eight leaves none. The datapath is five register stages (three
// for the modulo reduction, two for the rounding division, the second of them
// holding the compressed value) and a two-byte output buffer. A coefficient
// can be taken every cycle while the output buffer has room; sustained, the
// output port's one byte per cycle sets the pace. cfg_ready is always high;
// write cfg only while no coefficient is in flight, leftover bits are kept
// across a width change.
module lattice_coeff_compress_pack_top #(
	parameter int MODULUS = 7681
) (
	input  logic        clk,
	input  logic        arst_n,
	// width register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,   // [3:0] compress_bits
	// coefficient stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] coefficient
	// packed byte stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] packed_byte
	output logic        m_tlast     // last_of_run
);

	localparam int XW = $clog2(MODULUS);

	lccp_pkg::width_t cfg_q, d;
	logic             red_valid, red_ready;
	logic [XW-1:0]    x;
	logic             cmp_valid, cmp_ready;
	lccp_pkg::tval_t  t;

	// register accepts a transfer in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= lccp_pkg::D_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	assign d = lccp_pkg::eff_width(cfg_q);

	// x = coefficient mod q
	lccp_reduce #(
		.MODULUS (MODULUS)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.coeff     (s_tdata),
		.out_valid (red_valid),
		.out_ready (red_ready),
		.x         (x)
	);

	// t = round(x * 2^d / q) mod 2^d
	lccp_compress #(
		.MODULUS (MODULUS)
	) u_compress (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (red_valid),
		.in_ready  (red_ready),
		.x         (x),
		.d         (d),
		.out_valid (cmp_valid),
		.out_ready (cmp_ready),
		.t         (t)
	);

	// bit accumulator and byte output
	lccp_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmp_valid),
		.in_ready (cmp_ready),
		.t        (t),
		.d        (d),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ sv/lccp_reduce.sv @@
// Three-stage full reduction of a 16-bit coefficient modulo the lattice modulus.
`timescale 1ns / 1ps
module lccp_reduce #(
	parameter int MODULUS = 7681
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lccp_pkg::COEFF_W-1:0]        coeff,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [$clog2(MODULUS)-1:0]          x
);

	localparam int CW = lccp_pkg::COEFF_W;
	localparam int XW = $clog2(MODULUS);
	// floor(2^16/q): the quotient estimate is short by at most one
	localparam logic [CW-1:0] RECIP1 = CW'((64'd1 << CW) / MODULUS);
	localparam logic [CW-1:0] MOD_C  = CW'(MODULUS);

	logic          v1_q, v2_q, v3_q;
	logic          en1, en2, en3;
	logic [CW-1:0] coeff_s1, coeff_s2, est_s2;
	logic [XW-1:0] x_s3;
	logic [2*CW-1:0] prod1;
	logic [CW-1:0] back1, rem1, red1;

	assign en3      = !v3_q || out_ready;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign in_ready = en1;

	assign prod1 = (2*CW)'(coeff_s1) * (2*CW)'(RECIP1);
	assign back1 = CW'(est_s2 * MOD_C);
	assign rem1  = coeff_s2 - back1;
	assign red1  = (rem1 >= MOD_C) ? rem1 - MOD_C : rem1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= in_valid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			coeff_s1 <= coeff;
		end
		if (en2 && v1_q) begin
			coeff_s2 <= coeff_s1;
			est_s2   <= prod1[2*CW-1:CW];
		end
		if (en3 && v2_q) begin
			x_s3 <= red1[XW-1:0];
		end
	end

	assign out_valid = v3_q;
	assign x         = x_s3;

endmodule

@@ sv/lccp_compress.sv @@
// Two-stage rounding division round(x * 2^d / q) mod 2^d by reciprocal multiply.
`timescale 1ns / 1ps
module lccp_compress #(
	parameter int MODULUS = 7681
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [$clog2(MODULUS)-1:0] x,
	input  lccp_pkg::width_t           d,
	output logic                       out_valid,
	input  logic                       out_ready,
	output lccp_pkg::tval_t            t
);

	localparam int XW = $clog2(MODULUS);
	localparam int NW = XW + lccp_pkg::MAX_D + 1;  // numerator width
	localparam int PW = 2 * NW;
	localparam int QW = lccp_pkg::MAX_D + 1;       // quotient reaches 2^d
	localparam int TW = lccp_pkg::T_W;
	localparam logic [NW-1:0] RECIP2 = NW'((64'd1 << NW) / MODULUS);
	localparam logic [NW-1:0] HALF   = NW'(MODULUS / 2);
	localparam logic [NW-1:0] MOD_N  = NW'(MODULUS);

	logic          v4_q, v5_q;
	logic          en4, en5;
	logic [NW-1:0] num, num_s4, back2, rem2;
	logic [PW-1:0] prod2;
	logic [QW-1:0] est_s4, quo;
	logic [QW-1:0] mask;
	logic [TW-1:0] t_s5;

	assign en5      = !v5_q || out_ready;
	assign en4      = !v4_q || en5;
	assign in_ready = en4;

	assign num   = (NW'(x) << d) + HALF;
	assign prod2 = PW'(num) * PW'(RECIP2);

	// estimate is floor or one below; a single compare fixes it
	assign back2 = NW'(NW'(est_s4) * MOD_N);
	assign rem2  = num_s4 - back2;
	assign quo   = (rem2 >= MOD_N) ? est_s4 + QW'(1) : est_s4;
	assign mask  = (QW'(1) << d) - QW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (en4) begin
				v4_q <= in_valid;
			end
			if (en5) begin
				v5_q <= v4_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && in_valid) begin
			num_s4 <= num;
			est_s4 <= prod2[NW +: QW];
		end
		if (en5 && v4_q) begin
			t_s5 <= TW'(quo & mask);
		end
	end

	assign out_valid = v5_q;
	assign t         = t_s5;

endmodule

@@ sv/lccp_pack.sv @@
// Bit accumulator and two-byte output buffer for the packed stream.
`timescale 1ns / 1ps
module lccp_pack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lccp_pkg::tval_t      t,
	input  lccp_pkg::width_t     d,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output lccp_pkg::byte_t      m_tdata,
	output logic                 m_tlast
);

	localparam int ACC_W  = lccp_pkg::ACC_W;
	localparam int PEND_W = lccp_pkg::PEND_W;
	localparam int CNT_W  = lccp_pkg::CNT_W;
	localparam int TOT_W  = lccp_pkg::TOT_W;
	localparam int BW     = lccp_pkg::BYTE_W;

	logic [PEND_W-1:0] pend_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [1:0]        buf_n_q;
	lccp_pkg::byte_t   head_q, tail_q;
	logic              take, pop, two;
	logic [ACC_W-1:0]  acc;
	logic [TOT_W-1:0]  total;

	// room once the buffer is empty or its last byte leaves this cycle
	assign pop      = m_tvalid && m_tready;
	assign in_ready = (buf_n_q == 2'd0) || ((buf_n_q == 2'd1) && m_tready);
	assign take     = in_valid && in_ready;

	assign acc   = ACC_W'(pend_q) | (ACC_W'(t) << cnt_q);
	assign total = TOT_W'(cnt_q) + TOT_W'(d);
	assign two   = total >= TOT_W'(16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			cnt_q   <= '0;
			buf_n_q <= 2'd0;
		end else begin
			if (take) begin
				cnt_q   <= total[CNT_W-1:0];
				buf_n_q <= two ? 2'd2 : 2'd1;
				if (two) begin
					pend_q <= PEND_W'(acc[ACC_W-1:2*BW]);
				end else begin
					pend_q <= acc[BW +: PEND_W];
				end
			end else if (pop) begin
				buf_n_q <= buf_n_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			head_q <= acc[BW-1:0];
			tail_q <= acc[2*BW-1:BW];
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

	assign m_tvalid = buf_n_q != 2'd0;
	assign m_tdata  = head_q;
	assign m_tlast  = buf_n_q == 2'd1;

`ifndef NO_ASSERTIONS
	a_buf_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		buf_n_q != 2'd3)
		else $error("output buffer count out of range");

	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q >> cnt_q) == '0)
		else $error("stray bits above the leftover count");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> buf_n_q != 2'd2)
		else $error("new value loaded over two waiting bytes");

	a_drain_one: assert property (@(posedge clk) disable iff (!arst_n)
		buf_n_q == 2'd2 |=> buf_n_q != 2'd0)
		else $error("two bytes drained in one cycle");

	a_t_fits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> (t >> d) == '0)
		else $error("compressed value wider than the selected width");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the coefficient compress-and-pack block.
`timescale 1ns / 1ps
module testbench;

	localparam int MODULUS     = 7681;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 119;
	localparam int SETTLE      = 12;      // pipeline depth plus output buffer, with margin
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX  = 10;

	// flow-control modes, one per phase in turn
	localparam int FLOW_FREE    = 0;
	localparam int FLOW_SRC_GAP = 1;
	localparam int FLOW_SNK_GAP = 2;
	localparam int FLOW_BOTH    = 3;

	typedef struct packed {
		lccp_pkg::byte_t data;
		logic            last;
	} packed_byte_t;

	// corner coefficients: zero, rounding ties, wrap to 2^d, multiples of q, all-ones
	localparam logic [15:0] CORNER_COEFFS [19] = '{
		16'd0, 16'd1, 16'd2, 16'd960, 16'd961, 16'd3840, 16'd3841,
		16'd7679, 16'd7680, 16'd7681, 16'd7682, 16'd15362, 16'd61447,
		16'd61448, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF
	};

	// raw register codes per phase: every width, and codes either side of the range
	localparam lccp_pkg::width_t WIDTH_CODES [PHASES] = '{
		4'd8, 4'd9, 4'd10, 4'd11, 4'd0, 4'd15,
		4'd7, 4'd12, 4'd9, 4'd10, 4'd8, 4'd11
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	lattice_coeff_compress_pack_top #(
		.MODULUS(MODULUS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// predictor state
	lccp_pkg::width_t width_code;
	logic [6:0]       leftover_bits;
	logic [2:0]       leftover_count;
	packed_byte_t     packed_bytes_due[$];
	logic [15:0]      coeff_q[$];

	int flow_mode;
	int mismatches;
	int coeffs_taken;
	int bytes_seen;
	int runs_closed;
	int cycle_count;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// reduce, round to d bits, append above the leftover and queue every whole byte
	function automatic void compress_and_pack(input logic [15:0] coeff);
		int unsigned  d;
		int unsigned  x;
		int unsigned  t;
		int unsigned  acc;
		int unsigned  total;
		int           n;
		packed_byte_t b;
		d = width_code;
		if (width_code < lccp_pkg::D_MIN) begin
			d = lccp_pkg::D_MIN;
		end else if (width_code > lccp_pkg::D_MAX) begin
			d = lccp_pkg::D_MAX;
		end
		x = coeff % MODULUS;
		t = ((x << d) + MODULUS / 2) / MODULUS;
		t = t & ((1 << d) - 1);
		acc = leftover_bits | (t << leftover_count);
		total = leftover_count + d;
		n = 0;
		while (total >= 8 && n < 2) begin
			b.data = acc[7:0];
			b.last = 1'b0;
			packed_bytes_due.push_back(b);
			acc = acc >> 8;
			total = total - 8;
			n++;
		end
		if (n > 0) begin
			packed_bytes_due[$].last = 1'b1;
		end
		leftover_bits = acc[6:0];
		leftover_count = total[2:0];
	endfunction

	function automatic logic [15:0] random_coeff();
		int unsigned pick;
		int unsigned k;
		pick = $urandom_range(9);
		k = $urandom_range(8);
		if (pick < 6) begin
			return 16'($urandom);
		end else if (pick < 8) begin
			return 16'($urandom_range(MODULUS - 1));
		end else begin
			// close to a multiple of q, wrapping round for the low end
			return 16'(k * MODULUS + $urandom_range(6) - 3);
		end
	endfunction

	function automatic bit gap_now(input bit sender);
		int pct;
		pct = 0;
		if (flow_mode == FLOW_BOTH) begin
			pct = 8;
		end else if (sender && flow_mode == FLOW_SRC_GAP) begin
			pct = 61;
		end else if (!sender && flow_mode == FLOW_SNK_GAP) begin
			pct = 61;
		end
		return $urandom_range(99) < pct;
	endfunction

	// coefficient driver: predict on each transfer, then offer the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				compress_and_pack(s_tdata);
				coeffs_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (coeff_q.size() != 0 && !gap_now(1'b1)) begin
					s_tdata <= coeff_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// byte monitor: check each transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				bytes_seen++;
				if (m_tlast) begin
					runs_closed++;
				end
				if (packed_bytes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("unexpected byte %02h last %0b", m_tdata, m_tlast);
					end
				end else begin
					if (m_tdata !== packed_bytes_due[0].data
							|| m_tlast !== packed_bytes_due[0].last) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("byte %0d: expected %02h last %0b, got %02h last %0b",
								bytes_seen, packed_bytes_due[0].data,
								packed_bytes_due[0].last, m_tdata, m_tlast);
						end
					end
					void'(packed_bytes_due.pop_front());
				end
			end
			m_tready <= !gap_now(1'b0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes outstanding",
				cycle_count, packed_bytes_due.size());
			$display("lattice_coeff_compress_pack_top verification failed");
			$finish;
		end
	end

	// checked at the falling edge so all rising-edge updates have settled
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (coeff_q.size() != 0 || s_tvalid || packed_bytes_due.size() != 0);
	endtask

	task automatic write_width(input lccp_pkg::width_t code);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= code;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		width_code = code;
	endtask

	initial begin
		int p;
		int i;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		width_code = lccp_pkg::D_RESET;
		leftover_bits = '0;
		leftover_count = '0;
		flow_mode = FLOW_FREE;
		mismatches = 0;
		coeffs_taken = 0;
		bytes_seen = 0;
		runs_closed = 0;
		cycle_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// corners at the reset width
		foreach (CORNER_COEFFS[j]) begin
			coeff_q.push_back(CORNER_COEFFS[j]);
		end
		wait_drained();

		// leftover bits carry across each width change
		for (p = 0; p < PHASES; p++) begin
			repeat (SETTLE) @(posedge clk);
			write_width(WIDTH_CODES[p]);
			flow_mode = p % 4;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				coeff_q.push_back(random_coeff());
				// sender holds off mid-phase until the output has caught up
				if (p % 3 == 1 && i == PHASE_ITEMS / 2) begin
					wait_drained();
				end
			end
			wait_drained();
		end

		flow_mode = FLOW_FREE;
		repeat (SETTLE * 2) @(posedge clk);
		$display("covered %0d coefficients giving %0d bytes in %0d runs", coeffs_taken,
			bytes_seen, runs_closed);
		$display("widths 8 to 11 and out-of-range codes, four flow-control modes, %0d mismatches",
			mismatches);
		if (mismatches == 0 && packed_bytes_due.size() == 0) begin
			$display("lattice_coeff_compress_pack_top verification clean");
		end else begin
			$display("lattice_coeff_compress_pack_top verification failed");
		end
		$finish;
	end

endmodule
